// ===== rtl/core/first_fit_free_list_allocator_assert.svh =====
// Assertion macros for the free-list allocator checker.
// Depends on nothing; included by the checker file.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define FFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/ffa_pkg.sv =====
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
package ffa_pkg;
  localparam int unsigned DefaultRanges = 128;
  localparam logic [30:0] DefaultRegion = 31'd67108864;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  typedef struct packed {
    logic       action;
    logic [4:0] alignment_log2;
    logic [30:0] block_offset;
    logic [30:0] block_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] alloc_offset;
    logic [30:0] free_bytes;
  } rsp_t;
endpackage

// ===== rtl/core/ffa_chan_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
interface ffa_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list allocator: sequencer, shared adder path.
// Depends on ffa_pkg, ffa_chan_if and ffa_table.
//
// channel | dir | payload
// in      | in  | action, alignment_log2, block_offset, block_size
// out     | out | status, alloc_offset, free_bytes
// cfg     | in  | region_size
//
// A request scans the table one entry at a time (memory read, then compare);
// a removal then shifts each later entry down one slot (read, then write).
// Reset leaves one range (0, DefaultRegion); a region_size write leaves one range (0, region_size).
// in_ready is low from acceptance until the result is taken on out.
module first_fit_free_list_allocator #(
  parameter int unsigned MAX_FREE_RANGES = ffa_pkg::DefaultRanges
) (
  input  logic clk,
  input  logic rst_n,
  ffa_chan_if.sink   in_ch,
  ffa_chan_if.source out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_region_size
);
  localparam int unsigned AW = $clog2(MAX_FREE_RANGES);
  localparam int unsigned CW = $clog2(MAX_FREE_RANGES + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_FREE_RANGES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SHRD = 3'd3;
  localparam logic [2:0] S_SHWR = 3'd4;
  localparam logic [2:0] S_APP  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  ffa_pkg::req_t req_r, req_nxt;
  ffa_pkg::rsp_t rsp_r, rsp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [30:0] free_r, free_nxt;
  logic [30:0] app_start_r, app_start_nxt;
  logic [30:0] app_len_r, app_len_nxt;
  logic        app_r, app_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [30:0]   wstart, wlen, rstart, rlen;

  logic [31:0] amask, pad, need;
  logic [30:0] bend, rend;

  ffa_table #(.DEPTH(MAX_FREE_RANGES), .AW(AW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wstart(wstart), .wlen(wlen),
    .raddr(raddr), .rstart(rstart), .rlen(rlen)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.payload = rsp_r;

  assign amask = (32'd1 << req_r.alignment_log2) - 32'd1;
  assign pad = (amask + 32'd1 - ({1'b0, rstart} & amask)) & amask;
  assign need = {1'b0, req_r.block_size} + pad;
  assign bend = req_r.block_offset + req_r.block_size;
  assign rend = rstart + rlen;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    rsp_nxt = rsp_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    free_nxt = free_r;
    app_start_nxt = app_start_r;
    app_len_nxt = app_len_r;
    app_nxt = app_r;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wstart = 31'd0;
    wlen = 31'd0;
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          we = 1'b1;
          waddr = '0;
          wlen = cfg_region_size;
          cnt_nxt = CW'(1);
          free_nxt = cfg_region_size;
        end else if (in_ch.valid) begin
          req_nxt = in_ch.payload;
          idx_nxt = '0;
          app_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (idx_r >= cnt_r) begin
          if (req_r.action == ffa_pkg::ACT_ALLOC) begin
            rsp_nxt = '{ffa_pkg::ST_NOFIT, 31'd0, free_r};
            state_nxt = S_OUT;
          end else if (cnt_r >= CntMax) begin
            rsp_nxt = '{ffa_pkg::ST_FULL, 31'd0, free_r};
            state_nxt = S_OUT;
          end else begin
            app_start_nxt = req_r.block_offset;
            app_len_nxt = req_r.block_size;
            free_nxt = free_r + req_r.block_size;
            state_nxt = S_APP;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_RD;
        idx_nxt = idx_r + CW'(1);
        if (req_r.action == ffa_pkg::ACT_FREE) begin
          if (rend == req_r.block_offset || rstart == bend) begin
            we = 1'b1;
            wstart = (rend == req_r.block_offset) ? rstart : rstart - req_r.block_size;
            wlen = rlen + req_r.block_size;
            free_nxt = free_r + req_r.block_size;
            rsp_nxt = '{ffa_pkg::ST_OK, 31'd0, free_r + req_r.block_size};
            state_nxt = S_OUT;
          end
        end else if (need <= {1'b0, rlen}) begin
          app_start_nxt = rstart;
          app_len_nxt = pad[30:0];
          app_nxt = (pad != 32'd0);
          if (need != {1'b0, rlen}) begin
            if (pad != 32'd0 && cnt_r >= CntMax) begin
              rsp_nxt = '{ffa_pkg::ST_FULL, 31'd0, free_r};
              state_nxt = S_OUT;
            end else begin
              we = 1'b1;
              wstart = rstart + need[30:0];
              wlen = rlen - need[30:0];
              free_nxt = free_r - req_r.block_size;
              rsp_nxt = '{ffa_pkg::ST_OK, rstart + pad[30:0], free_r - req_r.block_size};
              state_nxt = (pad != 32'd0) ? S_APP : S_OUT;
            end
          end else begin
            free_nxt = free_r - req_r.block_size;
            rsp_nxt = '{ffa_pkg::ST_OK, rstart + pad[30:0], free_r - req_r.block_size};
            cnt_nxt = cnt_r - CW'(1);
            idx_nxt = idx_r;
            state_nxt = S_SHRD;
          end
        end
      end
      S_SHRD: begin
        if (idx_r >= cnt_r) begin
          state_nxt = app_r ? S_APP : S_OUT;
        end else begin
          raddr = AW'(idx_r + CW'(1));
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1;
        wstart = rstart;
        wlen = rlen;
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_SHRD;
      end
      S_APP: begin
        we = 1'b1;
        waddr = cnt_r[AW-1:0];
        wstart = app_start_r;
        wlen = app_len_r;
        cnt_nxt = cnt_r + CW'(1);
        if (req_r.action == ffa_pkg::ACT_FREE)
          rsp_nxt = '{ffa_pkg::ST_OK, 31'd0, free_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (!rst_n) begin
      we = 1'b1;
      waddr = '0;
      wstart = 31'd0;
      wlen = ffa_pkg::DefaultRegion;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= CW'(1);
      free_r <= ffa_pkg::DefaultRegion;
      idx_r <= '0;
      app_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      free_r <= free_nxt;
      idx_r <= idx_nxt;
      app_r <= app_nxt;
    end
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
    app_start_r <= app_start_nxt;
    app_len_r <= app_len_nxt;
  end
endmodule

// ===== rtl/core/ffa_table.sv =====
// Free-range table memory: start and length arrays, one write and one read port.
// Depends on nothing but its parameters.
module ffa_table #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [30:0]   wstart,
  input  logic [30:0]   wlen,
  input  logic [AW-1:0] raddr,
  output logic [30:0]   rstart,
  output logic [30:0]   rlen
);
  logic [30:0] start_mem [DEPTH];
  logic [30:0] len_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[waddr] <= wstart;
      len_mem[waddr] <= wlen;
    end
    rstart <= start_mem[raddr];
    rlen <= len_mem[raddr];
  end
endmodule

// ===== rtl/core/ffa_checker.sv =====
// Port-level checker for the first-fit free-list allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_free_list_allocator_assert.svh.
`include "first_fit_free_list_allocator_assert.svh"
module ffa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [30:0] out_alloc_offset,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  `FFA_ASSERT_IMP(a_no_ready_while_out, clk, rst_n, out_valid, !in_ready)
  `FFA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `FFA_ASSERT_IMP(a_status_legal, clk, rst_n, out_valid,
    out_status == ffa_pkg::ST_OK || out_status == ffa_pkg::ST_NOFIT ||
    out_status == ffa_pkg::ST_FULL)
  `FFA_ASSERT_IMP(a_offset_zero_on_fail, clk, rst_n,
    out_valid && out_status != ffa_pkg::ST_OK, out_alloc_offset == 31'd0)
  `FFA_ASSERT_IMP(a_cfg_only_idle, clk, rst_n, cfg_valid && cfg_ready, !out_valid)
endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.payload.status), .out_alloc_offset(out_ch.payload.alloc_offset),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// ===== tb/tb.sv =====
// Self-checking testbench for first_fit_free_list_allocator.
// Depends on ffa_pkg and ffa_chan_if; predicts every response from a model of
// the free-range table and checks each response field by field.
module tb;
  localparam int unsigned TableDepth = 128;
  localparam int unsigned DrainCycles = 2 * TableDepth + TableDepth + 40;
  localparam int unsigned StallLimit = 20000;
  localparam logic [30:0] AllOnes = 31'h7FFFFFFF;

  typedef struct {
    logic [30:0] offset;
    logic [30:0] size;
  } block_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [30:0] cfg_region_size;

  ffa_chan_if #(.payload_t(ffa_pkg::req_t)) in_ch ();
  ffa_chan_if #(.payload_t(ffa_pkg::rsp_t)) out_ch ();

  first_fit_free_list_allocator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_region_size(cfg_region_size)
  );

  always #1 clk = ~clk;

  logic [30:0] range_start [TableDepth];
  logic [30:0] range_len [TableDepth];
  int unsigned range_cnt;
  logic [30:0] free_total;
  ffa_pkg::rsp_t expected_rsp [$];
  block_t live_blocks [$];
  int error_count = 0;
  bit calm = 1'b0;
  bit hold_out = 1'b0;
  int idle_cycles = 0;

  task automatic report(input string what, input logic [30:0] got, input logic [30:0] want);
    error_count++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic void table_reset(input logic [30:0] region);
    for (int k = 0; k < TableDepth; k++) begin
      range_start[k] = '0;
      range_len[k] = '0;
    end
    range_len[0] = region;
    range_cnt = 1;
    free_total = region;
  endfunction

  function automatic void table_append(input logic [30:0] st, input logic [30:0] len);
    range_start[range_cnt] = st;
    range_len[range_cnt] = len;
    range_cnt++;
  endfunction

  function automatic void table_remove(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < range_cnt; k++) begin
      range_start[k] = range_start[k + 1];
      range_len[k] = range_len[k + 1];
    end
    range_cnt--;
    range_start[range_cnt] = '0;
    range_len[range_cnt] = '0;
  endfunction

  function automatic ffa_pkg::rsp_t alloc_predict(input logic [4:0] align_log2,
                                                  input logic [30:0] size);
    logic [63:0] amask, st, len, pad, need;
    ffa_pkg::rsp_t r;
    r = '0;
    r.status = ffa_pkg::ST_NOFIT;
    amask = (64'd1 << align_log2) - 64'd1;
    for (int unsigned i = 0; i < range_cnt; i++) begin
      st = {33'd0, range_start[i]};
      len = {33'd0, range_len[i]};
      pad = (amask + 64'd1 - (st & amask)) & amask;
      need = {33'd0, size} + pad;
      if (need > len) continue;
      if (need < len) begin
        if (pad != 0 && range_cnt >= TableDepth) begin
          r.status = ffa_pkg::ST_FULL;
          break;
        end
        if (pad != 0) table_append(st[30:0], pad[30:0]);
        range_start[i] = st[30:0] + need[30:0];
        range_len[i] = len[30:0] - need[30:0];
      end else begin
        table_remove(i);
        if (pad != 0) table_append(st[30:0], pad[30:0]);
      end
      free_total = free_total - size;
      r.status = ffa_pkg::ST_OK;
      r.alloc_offset = st[30:0] + pad[30:0];
      break;
    end
    r.free_bytes = free_total;
    return r;
  endfunction

  function automatic ffa_pkg::rsp_t free_predict(input logic [30:0] off,
                                                 input logic [30:0] size);
    logic [30:0] bend;
    ffa_pkg::rsp_t r;
    bit merged;
    r = '0;
    merged = 1'b0;
    bend = off + size;
    for (int unsigned i = 0; i < range_cnt; i++) begin
      if (range_start[i] + range_len[i] == off) begin
        range_len[i] = range_len[i] + size;
        merged = 1'b1;
        break;
      end
      if (range_start[i] == bend) begin
        range_start[i] = range_start[i] - size;
        range_len[i] = range_len[i] + size;
        merged = 1'b1;
        break;
      end
    end
    if (!merged && range_cnt >= TableDepth) begin
      r.status = ffa_pkg::ST_FULL;
    end else begin
      if (!merged) table_append(off, size);
      free_total = free_total + size;
      r.status = ffa_pkg::ST_OK;
    end
    r.free_bytes = free_total;
    return r;
  endfunction

  task automatic send_req(input logic act, input logic [4:0] align_log2,
                          input logic [30:0] off, input logic [30:0] size);
    ffa_pkg::req_t req;
    ffa_pkg::rsp_t r;
    block_t b;
    if (!calm && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req.action = act;
    req.alignment_log2 = align_log2;
    req.block_offset = off;
    req.block_size = size;
    in_ch.valid <= 1'b1;
    in_ch.payload <= req;
    do @(posedge clk); while (!in_ch.ready);
    r = (act == ffa_pkg::ACT_ALLOC) ? alloc_predict(align_log2, size) :
                                      free_predict(off, size);
    expected_rsp = {expected_rsp, r};
    if (act == ffa_pkg::ACT_ALLOC && r.status == ffa_pkg::ST_OK) begin
      b.offset = r.alloc_offset;
      b.size = size;
      live_blocks = {live_blocks, b};
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_region(input logic [30:0] region);
    drain();
    cfg_valid <= 1'b1;
    cfg_region_size <= region;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_reset(region);
    live_blocks.delete();
    @(posedge clk);
  endtask

  task automatic free_live_block();
    int idx;
    block_t b;
    idx = $urandom_range(live_blocks.size() - 1);
    b = live_blocks[idx];
    live_blocks.delete(idx);
    send_req(ffa_pkg::ACT_FREE, 5'($urandom_range(31)), b.offset, b.size);
  endtask

  task automatic test_directed();
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, 31'd0);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, AllOnes, 31'd100);
    send_req(ffa_pkg::ACT_ALLOC, 5'd12, '0, 31'd8);
    send_req(ffa_pkg::ACT_ALLOC, 5'd16, '0, 31'd1);
    send_req(ffa_pkg::ACT_ALLOC, 5'd31, '0, 31'd1);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, AllOnes);
    send_req(ffa_pkg::ACT_FREE, 5'd0, 31'd0, 31'd100);
    send_req(ffa_pkg::ACT_FREE, 5'd0, AllOnes, AllOnes);
    send_req(ffa_pkg::ACT_FREE, 5'd0, 31'd5000, 31'd0);
    send_req(ffa_pkg::ACT_ALLOC, 5'd3, '0, 31'd7);
    send_req(ffa_pkg::ACT_FREE, 5'd31, 31'h40000000, 31'h12345);
  endtask

  task automatic test_region_extremes();
    write_region(31'd0);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, 31'd0);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, 31'd0);
    send_req(ffa_pkg::ACT_FREE, 5'd0, 31'd0, 31'd0);
    write_region(31'd1);
    send_req(ffa_pkg::ACT_ALLOC, 5'd1, '0, 31'd1);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, 31'd1);
    write_region(AllOnes);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, AllOnes);
    send_req(ffa_pkg::ACT_FREE, 5'd0, 31'd0, AllOnes);
    send_req(ffa_pkg::ACT_ALLOC, 5'd20, '0, 31'h10000);
  endtask

  task automatic test_table_full();
    write_region(31'd1000);
    for (int i = 0; i < TableDepth + 2; i++)
      send_req(ffa_pkg::ACT_FREE, 5'd0, 31'd4000 + 31'(i * 8), 31'd1);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, 31'd3);
    send_req(ffa_pkg::ACT_ALLOC, 5'd4, '0, 31'd1);
    send_req(ffa_pkg::ACT_ALLOC, 5'd0, '0, 31'd1);
  endtask

  task automatic random_phase(input int count, input int max_size, input int max_align);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 50 || live_blocks.size() == 0)
        send_req(ffa_pkg::ACT_ALLOC, 5'($urandom_range(max_align)), 31'($urandom),
                 31'($urandom_range(max_size)));
      else if (roll < 88)
        free_live_block();
      else if (roll < 94)
        send_req(ffa_pkg::ACT_ALLOC, 5'($urandom_range(31)), 31'($urandom),
                 31'($urandom));
      else
        send_req(1'($urandom_range(1)), 5'($urandom), 31'($urandom), 31'($urandom));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      random_phase(6, 64, 4);
    join
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_out) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    ffa_pkg::rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected response", out_ch.payload.free_bytes, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (out_ch.payload.status !== want.status)
          report("status", 31'(out_ch.payload.status), 31'(want.status));
        if (out_ch.payload.alloc_offset !== want.alloc_offset)
          report("alloc_offset", out_ch.payload.alloc_offset, want.alloc_offset);
        if (out_ch.payload.free_bytes !== want.free_bytes)
          report("free_bytes", out_ch.payload.free_bytes, want.free_bytes);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_region_size <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    table_reset(ffa_pkg::DefaultRegion);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_region_extremes();
    test_table_full();
    write_region(31'd65536);
    random_phase(100, 2048, 6);
    calm = 1'b1;
    random_phase(100, 2048, 6);
    calm = 1'b0;
    test_backpressure();
    write_region(31'd4096);
    random_phase(200, 300, 8);
    write_region(ffa_pkg::DefaultRegion);
    random_phase(100, 1 << 20, 16);
    drain();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
